FILE: rtl/wes_pkg.sv
package wes_pkg;

  localparam int NUM_SLOTS  = 4;
  localparam int WHEELS_DEF = 4;
  localparam int CNT_W      = 16;
  localparam int SPD_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd3;

  localparam logic [3:0]  DIR_INV_RST  = 4'd0;
  localparam logic [7:0]  WIN_TICK_RST = 8'd10;
  localparam logic [23:0] RPM_SCL_RST  = 24'd297891;
  localparam logic [16:0] ALPHA_RST    = 17'd16384;
  localparam logic [16:0] ALPHA_ONE    = 17'd65536;

  typedef struct packed {
    logic load;
    logic acc;
    logic mul1;
    logic diff;
    logic mul2;
    logic upd;
    logic out_load;
  } wes_cmd_t;

  typedef struct packed {
    logic close;
  } wes_sts_t;

endpackage

FILE: rtl/wes_in_if.sv
interface wes_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] count_front_left;
  logic [15:0] count_front_right;
  logic [15:0] count_rear_left;
  logic [15:0] count_rear_right;

  modport source (
    output valid, mode, count_front_left, count_front_right, count_rear_left,
           count_rear_right,
    input  ready
  );
  modport sink (
    input  valid, mode, count_front_left, count_front_right, count_rear_left,
           count_rear_right,
    output ready
  );
endinterface

FILE: rtl/wes_out_if.sv
interface wes_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_front_left;
  logic signed [31:0] speed_front_right;
  logic signed [31:0] speed_rear_left;
  logic signed [31:0] speed_rear_right;
  logic signed [31:0] odometer_front_left;
  logic signed [31:0] odometer_front_right;
  logic signed [31:0] odometer_rear_left;
  logic signed [31:0] odometer_rear_right;
  logic               window_done;

  modport source (
    output valid, speed_front_left, speed_front_right, speed_rear_left,
           speed_rear_right, odometer_front_left, odometer_front_right,
           odometer_rear_left, odometer_rear_right, window_done,
    input  ready
  );
  modport sink (
    input  valid, speed_front_left, speed_front_right, speed_rear_left,
           speed_rear_right, odometer_front_left, odometer_front_right,
           odometer_rear_left, odometer_rear_right, window_done,
    output ready
  );
endinterface

FILE: rtl/wes_ctrl.sv
module wes_ctrl #(
  parameter int WHEELS = wes_pkg::WHEELS_DEF,
  parameter int WW     = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wes_pkg::wes_sts_t sts,
  output wes_pkg::wes_cmd_t cmd,
  output logic [WW-1:0]     wheel
);
  import wes_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ACC  = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_DIFF = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam logic [WW-1:0] LAST_WHEEL = WW'(WHEELS - 1);

  state_t        state_r, state_nxt;
  logic [WW-1:0] wheel_r, wheel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;
  logic          last_wheel;

  assign out_free   = !out_valid_r || out_ready;
  assign last_wheel = (wheel_r == LAST_WHEEL);

  always_comb begin
    state_nxt = state_r;
    wheel_nxt = wheel_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          wheel_nxt = '0;
          state_nxt = in_mode ? S_OUT : S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (last_wheel) begin
          wheel_nxt = '0;
          state_nxt = sts.close ? S_MUL1 : S_OUT;
        end else begin
          wheel_nxt = wheel_r + WW'(1);
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (last_wheel) begin
          wheel_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          wheel_nxt = wheel_r + WW'(1);
          state_nxt = S_MUL1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign wheel     = wheel_r;

endmodule

FILE: rtl/wes_dp.sv
module wes_dp #(
  parameter int WHEELS = wes_pkg::WHEELS_DEF,
  parameter int WW     = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  wes_pkg::wes_cmd_t                                   cmd,
  input  logic [WW-1:0]                                       wheel,
  output wes_pkg::wes_sts_t                                   sts,
  input  logic                                                in_mode,
  input  logic [wes_pkg::NUM_SLOTS-1:0][wes_pkg::CNT_W-1:0]   in_cnt,
  input  logic                                                cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0]                       cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]                      cfg_data,
  output logic [wes_pkg::NUM_SLOTS-1:0][wes_pkg::SPD_W-1:0]   out_spd,
  output logic [wes_pkg::NUM_SLOTS-1:0][wes_pkg::SPD_W-1:0]   out_odo,
  output logic                                                out_done
);
  import wes_pkg::*;

  function automatic logic [31:0] sat57(input logic [56:0] v);
    logic [31:0] r;
    if (v[56:31] != {26{v[56]}}) r = v[56] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat36(input logic [35:0] v);
    logic [31:0] r;
    if (v[35:31] != {5{v[35]}}) r = v[35] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  // configuration
  logic [3:0]  dir_inv_r;
  logic [7:0]  win_tick_r;
  logic [23:0] rpm_scl_r;
  logic [16:0] alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_inv_r  <= DIR_INV_RST;
      win_tick_r <= WIN_TICK_RST;
      rpm_scl_r  <= RPM_SCL_RST;
      alpha_r    <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIR_INV:  dir_inv_r  <= cfg_data[3:0];
        CFG_WIN_TICK: win_tick_r <= cfg_data[7:0];
        CFG_RPM_SCL:  rpm_scl_r  <= cfg_data[23:0];
        CFG_ALPHA:    alpha_r    <= cfg_data[16:0];
        default:      dir_inv_r  <= dir_inv_r;
      endcase
    end
  end

  // per-wheel state
  logic        [CNT_W-1:0] cnt_r  [WHEELS];
  logic        [CNT_W-1:0] prev_r [WHEELS];
  logic signed [31:0]      sum_r  [WHEELS];
  logic signed [31:0]      odo_r  [WHEELS];
  logic signed [31:0]      filt_r [WHEELS];
  logic        [7:0]       tick_r;
  logic                    close_r;

  logic        [7:0]  tick_inc;
  logic               close_c;
  logic [WHEELS-1:0]  inv_v;
  logic [CNT_W-1:0]   dlt;
  logic [16:0]        dlt_s;
  logic [16:0]        dlt_dir;
  logic [31:0]        dlt32;

  assign tick_inc = tick_r + 8'd1;
  // a zero window behaves as one tick, a wrapped count always closes
  assign close_c  = (tick_inc >= win_tick_r) || (tick_inc == 8'd0);

  assign inv_v   = dir_inv_r[WHEELS-1:0];
  assign dlt     = cnt_r[wheel] - prev_r[wheel];
  assign dlt_s   = {dlt[CNT_W-1], dlt};
  assign dlt_dir = inv_v[wheel] ? (17'd0 - dlt_s) : dlt_s;
  assign dlt32   = {{15{dlt_dir[16]}}, dlt_dir};

  // multiply and filter path
  logic signed [56:0] prod1_r;
  logic signed [32:0] diff_r;
  logic signed [50:0] prod2_r;
  logic        [16:0] alpha_eff;
  logic        [31:0] raw;
  logic        [50:0] rnd;
  logic        [34:0] step;
  logic        [35:0] filt_new;

  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign raw       = sat57(prod1_r);
  assign rnd       = prod2_r + 51'sd32768;
  assign step      = rnd[50:16];
  assign filt_new  = {{4{filt_r[wheel][31]}}, filt_r[wheel]} + {step[34], step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WHEELS; w++) begin
        prev_r[w] <= '0;
        sum_r[w]  <= '0;
        odo_r[w]  <= '0;
        filt_r[w] <= '0;
      end
      tick_r  <= '0;
      close_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (in_mode) begin
          for (int w = 0; w < WHEELS; w++) begin
            prev_r[w] <= in_cnt[w];
            sum_r[w]  <= '0;
            odo_r[w]  <= '0;
            filt_r[w] <= '0;
          end
          tick_r  <= '0;
          close_r <= 1'b0;
        end else begin
          tick_r  <= close_c ? 8'd0 : tick_inc;
          close_r <= close_c;
        end
      end
      if (cmd.acc) begin
        prev_r[wheel] <= cnt_r[wheel];
        sum_r[wheel]  <= sum_r[wheel] + dlt32;
        odo_r[wheel]  <= odo_r[wheel] + dlt32;
      end
      if (cmd.upd) begin
        filt_r[wheel] <= sat36(filt_new);
        sum_r[wheel]  <= '0;
      end
    end
  end

  logic [SPD_W-1:0] spd_out_r [WHEELS];
  logic [SPD_W-1:0] odo_out_r [WHEELS];
  logic             done_out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int w = 0; w < WHEELS; w++) cnt_r[w] <= in_cnt[w];
    end
    if (cmd.mul1) prod1_r <= sum_r[wheel] * $signed({1'b0, rpm_scl_r});
    if (cmd.diff) diff_r <= $signed({raw[31], raw}) - $signed({filt_r[wheel][31], filt_r[wheel]});
    if (cmd.mul2) prod2_r <= diff_r * $signed({1'b0, alpha_eff});
    if (cmd.out_load) begin
      for (int w = 0; w < WHEELS; w++) begin
        spd_out_r[w] <= filt_r[w];
        odo_out_r[w] <= odo_r[w];
      end
      done_out_r <= close_r;
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    if (g < WHEELS) begin : g_live
      assign out_spd[g] = spd_out_r[g];
      assign out_odo[g] = odo_out_r[g];
    end else begin : g_dead
      assign out_spd[g] = '0;
      assign out_odo[g] = '0;
    end
  end

  assign out_done  = done_out_r;
  assign sts.close = close_r;

endmodule

FILE: rtl/wheel_encoder_speed_estimator.sv
// a resync transaction loads its counts and passes straight to the output register, a
// normal tick first accumulates each wheel in turn, and a tick that closes a window then
// steps each wheel through mul1, diff, mul2 and upd on the two shared multipliers; a new
// transaction is taken only after the last result enters the output register
// reset: synchronous active-low rst_n clears the per-wheel sums, odometers, filters and
// previous counts, restores register defaults and empties the output register
module wheel_encoder_speed_estimator #(
  parameter int WHEELS = wes_pkg::WHEELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wes_in_if.sink                          in_ch,
  wes_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wes_pkg::*;

  localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  wes_cmd_t                       cmd;
  wes_sts_t                       sts;
  logic [WW-1:0]                  wheel;
  logic [NUM_SLOTS-1:0][CNT_W-1:0] in_cnt;
  logic [NUM_SLOTS-1:0][SPD_W-1:0] out_spd;
  logic [NUM_SLOTS-1:0][SPD_W-1:0] out_odo;
  logic                           out_done;

  assign in_cnt[0] = in_ch.count_front_left;
  assign in_cnt[1] = in_ch.count_front_right;
  assign in_cnt[2] = in_ch.count_rear_left;
  assign in_cnt[3] = in_ch.count_rear_right;

  wes_ctrl #(.WHEELS(WHEELS), .WW(WW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .wheel     (wheel)
  );

  wes_dp #(.WHEELS(WHEELS), .WW(WW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wheel     (wheel),
    .sts       (sts),
    .in_mode   (in_ch.mode),
    .in_cnt    (in_cnt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_spd   (out_spd),
    .out_odo   (out_odo),
    .out_done  (out_done)
  );

  assign out_ch.speed_front_left     = out_spd[0];
  assign out_ch.speed_front_right    = out_spd[1];
  assign out_ch.speed_rear_left      = out_spd[2];
  assign out_ch.speed_rear_right     = out_spd[3];
  assign out_ch.odometer_front_left  = out_odo[0];
  assign out_ch.odometer_front_right = out_odo[1];
  assign out_ch.odometer_rear_left   = out_odo[2];
  assign out_ch.odometer_rear_right  = out_odo[3];
  assign out_ch.window_done          = out_done;

endmodule

FILE: rtl/wes_checker.sv
module wes_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [256:0] out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wheel_encoder_speed_estimator wes_checker u_wes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.speed_front_left, out_ch.speed_front_right,
               out_ch.speed_rear_left, out_ch.speed_rear_right,
               out_ch.odometer_front_left, out_ch.odometer_front_right,
               out_ch.odometer_rear_left, out_ch.odometer_rear_right,
               out_ch.window_done})
);
